// ===== rtl/smr_pkg.sv =====
// Shared types and constants for the sync framed message receiver.
// No dependencies; imported by every module of the block.
package smr_pkg;

  localparam int PAYLOAD_LEN = 12;
  localparam int BYTE_W      = 8;
  localparam int IDX_W       = 4;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [BYTE_W-1:0] FIRST_SYNC_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SECOND_SYNC_RST = 8'h55;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SYNC  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_SYNC = 1'd1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_SUM_ERR = 1'b1;

  typedef logic [PAYLOAD_LEN-1:0][BYTE_W-1:0] payload_t;

  typedef struct packed {
    logic     status;
    payload_t payload;
  } frame_rec_t;

  typedef struct packed {
    logic       push;
    frame_rec_t rec;
  } frame_push_t;

endpackage

// ===== rtl/smr_front.sv =====
// Front end: sync hunt, payload capture, running checksum, config registers.
// Depends on smr_pkg; emits one frame record per checksum byte.
module smr_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [smr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [smr_pkg::BYTE_W-1:0]    cfg_wdata,
  input  logic                          byte_valid,
  input  logic [smr_pkg::BYTE_W-1:0]    byte_data,
  output smr_pkg::frame_push_t          fpush
);
  import smr_pkg::*;

  localparam logic [1:0] PH_SYNC_A = 2'd0;
  localparam logic [1:0] PH_SYNC_B = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;
  localparam logic [1:0] PH_SUM    = 2'd3;

  logic [1:0]        phase_r, phase_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [BYTE_W-1:0] first_r, second_r;
  logic [BYTE_W-1:0] payload_r [PAYLOAD_LEN];
  logic              wr_payload;

  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    sum_nxt    = sum_r;
    wr_payload = 1'b0;
    if (byte_valid) begin
      unique case (phase_r)
        PH_SYNC_A: begin
          if (byte_data == first_r) phase_nxt = PH_SYNC_B;
        end
        PH_SYNC_B: begin
          if (byte_data == second_r) begin
            phase_nxt = PH_DATA;
            idx_nxt   = '0;
            sum_nxt   = '0;
          end else if (byte_data == first_r) begin
            phase_nxt = PH_SYNC_B;
          end else begin
            phase_nxt = PH_SYNC_A;
          end
        end
        PH_DATA: begin
          wr_payload = (idx_r < IDX_W'(PAYLOAD_LEN));
          sum_nxt    = sum_r + byte_data;
          idx_nxt    = idx_r + 1'b1;
          if (idx_nxt >= IDX_W'(PAYLOAD_LEN)) phase_nxt = PH_SUM;
        end
        PH_SUM: begin
          phase_nxt = PH_SYNC_A;
        end
        default: phase_nxt = PH_SYNC_A;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SYNC_A;
      idx_r    <= '0;
      sum_r    <= '0;
      first_r  <= FIRST_SYNC_RST;
      second_r <= SECOND_SYNC_RST;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      sum_r   <= sum_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_FIRST_SYNC:  first_r  <= cfg_wdata;
          REG_SECOND_SYNC: second_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_payload) payload_r[idx_r] <= byte_data;
  end

  always_comb begin
    fpush.push       = byte_valid && (phase_r == PH_SUM);
    fpush.rec.status = (byte_data == sum_r) ? STATUS_OK : STATUS_SUM_ERR;
    for (int k = 0; k < PAYLOAD_LEN; k++) begin
      fpush.rec.payload[k] = payload_r[k];
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (idx_r < IDX_W'(PAYLOAD_LEN)))
    else $error("payload index out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    (byte_valid && phase_r == PH_DATA && idx_r == IDX_W'(PAYLOAD_LEN - 1)) |=>
    (phase_r == PH_SUM))
    else $error("checksum phase not entered after last payload byte");

  assert property (@(posedge clk) disable iff (!rst_n)
    fpush.push |=> (phase_r == PH_SYNC_A))
    else $error("parser did not return to sync hunt after checksum");

endmodule

// ===== rtl/smr_fifo.sv =====
// Short register queue of frame records between front end and back end.
// Depends on smr_pkg.
module smr_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  smr_pkg::frame_push_t fpush,
  output logic                 full,
  output logic                 empty,
  input  logic                 pop,
  output smr_pkg::frame_rec_t  head
);
  import smr_pkg::*;

  frame_rec_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = fpush.push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= fpush.rec;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count overflow");

  assert property (@(posedge clk) disable iff (!rst_n)
    fpush.push |-> !full)
    else $error("record pushed into full queue");

  assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not follow push");

endmodule

// ===== rtl/smr_back.sv =====
// Back end: decodes a frame record into result fields and holds them in
// the output register until popped. Depends on smr_pkg.
module smr_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  smr_pkg::frame_rec_t   q_head,
  output logic                  q_pop,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic                  out_frame_status,
  output logic [15:0]           out_pos_x,
  output logic [15:0]           out_pos_y,
  output logic                  out_camera_flag,
  output logic                  out_enable_flag,
  output logic signed [15:0]    out_angle_deg,
  output logic [15:0]           out_range_mm,
  output logic [15:0]           out_max_range_mm
);
  import smr_pkg::*;

  logic     valid_r;
  logic     load;
  payload_t p;

  assign load      = !q_empty && (!valid_r || out_pop);
  assign q_pop     = load;
  assign out_empty = !valid_r;

  always_comb begin
    p = (q_head.status == STATUS_OK) ? q_head.payload : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_frame_status <= q_head.status;
      out_pos_x        <= {p[1], p[0]};
      out_pos_y        <= {p[3], p[2]};
      out_camera_flag  <= |p[4];
      out_enable_flag  <= |p[5];
      out_angle_deg    <= signed'({p[7], p[6]});
      out_range_mm     <= {p[9], p[8]};
      out_max_range_mm <= {p[11], p[10]};
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_pop) |=> valid_r)
    else $error("result dropped without pop");

  assert property (@(posedge clk) disable iff (!rst_n)
    load |=> valid_r)
    else $error("loaded result not shown");

  assert property (@(posedge clk) disable iff (!rst_n)
    (load && q_head.status == STATUS_SUM_ERR) |=>
    (out_pos_x == '0 && out_range_mm == '0 && !out_camera_flag))
    else $error("fields not cleared on checksum error");

endmodule

// ===== rtl/sync_framed_message_receiver.sv =====
// Sync framed message receiver: top level.
// Depends on smr_pkg, smr_front, smr_fifo and smr_back.
//
// Input channel: a byte is taken when in_push is high and in_full is low.
// The parser hunts for the two sync bytes, stores a 12-byte payload with a
// modulo-256 sum, and on the following checksum byte produces one result.
// Result channel: while out_empty is low the oldest result is on the out_
// ports; it is consumed when out_pop is high. A checksum error gives
// out_frame_status high and all other fields zero.
// Config: cfg_we writes cfg_wdata to the sync byte register cfg_idx
// (0 first, 1 second) in the same edge. Write only while idle.
// Throughput: one byte per cycle while in_full is low. The record of an
// accepted checksum byte is written into the queue at the accepting edge
// and then loaded into the output register once that register is free.
// A 2-entry record queue plus the output register decouple the sides;
// in_full rises only when the queue is full, i.e. when the consumer has
// stalled with three results pending. Synchronous reset (rst_n low)
// restores the sync hunt, default sync bytes 0xAA/0x55 and drops results.
module sync_framed_message_receiver (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [smr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [smr_pkg::BYTE_W-1:0]    cfg_wdata,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [smr_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic                          out_frame_status,
  output logic [15:0]                   out_pos_x,
  output logic [15:0]                   out_pos_y,
  output logic                          out_camera_flag,
  output logic                          out_enable_flag,
  output logic signed [15:0]            out_angle_deg,
  output logic [15:0]                   out_range_mm,
  output logic [15:0]                   out_max_range_mm
);
  import smr_pkg::*;

  frame_push_t fpush;
  frame_rec_t  q_head;
  logic        q_full, q_empty, q_pop;
  logic        in_take;

  assign in_full = q_full;
  assign in_take = in_push && !q_full;

  smr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .byte_valid (in_take),
    .byte_data  (in_rx_byte),
    .fpush      (fpush)
  );

  smr_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .fpush (fpush),
    .full  (q_full),
    .empty (q_empty),
    .pop   (q_pop),
    .head  (q_head)
  );

  smr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_frame_status (out_frame_status),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_camera_flag  (out_camera_flag),
    .out_enable_flag  (out_enable_flag),
    .out_angle_deg    (out_angle_deg),
    .out_range_mm     (out_range_mm),
    .out_max_range_mm (out_max_range_mm)
  );

endmodule

// ===== bench/smr_frame_checker.sv =====
`timescale 1ns / 1ps
// Frame checker for the sync framed message receiver: tracks sync byte writes
// and accepted bytes, predicts each frame result and compares it when popped.
// Depends on smr_pkg.
module smr_frame_checker
  import smr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [BYTE_W-1:0]    cfg_wdata,
  input  logic                 in_push,
  input  logic                 in_full,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  input  logic                 out_empty,
  input  logic                 out_pop,
  input  logic                 out_frame_status,
  input  logic [15:0]          out_pos_x,
  input  logic [15:0]          out_pos_y,
  input  logic                 out_camera_flag,
  input  logic                 out_enable_flag,
  input  logic signed [15:0]   out_angle_deg,
  input  logic [15:0]          out_range_mm,
  input  logic [15:0]          out_max_range_mm,
  output int                   mismatches,
  output int                   outstanding
);

  typedef enum logic [1:0] {HUNT_FIRST, HUNT_SECOND, IN_PAYLOAD, AT_CHECKSUM} parse_state_e;

  typedef struct packed {
    logic               status;
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic               camera;
    logic               enable;
    logic signed [15:0] angle;
    logic [15:0]        range_mm;
    logic [15:0]        max_range;
  } frame_fields_t;

  logic [BYTE_W-1:0] sync_first;
  logic [BYTE_W-1:0] sync_second;
  parse_state_e      state;
  logic [IDX_W-1:0]  stored;
  logic [BYTE_W-1:0] sum;
  payload_t          payload;
  frame_fields_t     expected_frames[$];
  int                errors = 0;

  assign mismatches = errors;

  function automatic void parse_byte(input logic [BYTE_W-1:0] b);
    frame_fields_t f;
    f = '0;
    case (state)
      HUNT_FIRST: begin
        if (b == sync_first) state = HUNT_SECOND;
      end
      HUNT_SECOND: begin
        if (b == sync_second) begin
          state  = IN_PAYLOAD;
          stored = '0;
          sum    = '0;
        end else if (b != sync_first) begin
          state = HUNT_FIRST;
        end
      end
      IN_PAYLOAD: begin
        if (stored < PAYLOAD_LEN) payload[stored] = b;
        sum    = sum + b;
        stored = stored + 1'b1;
        if (stored >= PAYLOAD_LEN) state = AT_CHECKSUM;
      end
      default: begin
        if (b == sum) begin
          f.status    = STATUS_OK;
          f.pos_x     = {payload[1], payload[0]};
          f.pos_y     = {payload[3], payload[2]};
          f.camera    = |payload[4];
          f.enable    = |payload[5];
          f.angle     = {payload[7], payload[6]};
          f.range_mm  = {payload[9], payload[8]};
          f.max_range = {payload[11], payload[10]};
        end else begin
          f.status = STATUS_SUM_ERR;
        end
        expected_frames.push_back(f);
        state = HUNT_FIRST;
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function automatic void compare_frame(input frame_fields_t want);
    check_field("frame_status", want.status, out_frame_status);
    check_field("pos_x", want.pos_x, out_pos_x);
    check_field("pos_y", want.pos_y, out_pos_y);
    check_field("camera_flag", want.camera, out_camera_flag);
    check_field("enable_flag", want.enable, out_enable_flag);
    check_field("angle_deg", $signed(want.angle), out_angle_deg);
    check_field("range_mm", want.range_mm, out_range_mm);
    check_field("max_range_mm", want.max_range, out_max_range_mm);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      sync_first  = FIRST_SYNC_RST;
      sync_second = SECOND_SYNC_RST;
      state       = HUNT_FIRST;
      stored      = '0;
      sum         = '0;
      expected_frames.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_frames.size() == 0) begin
          $error("result transaction with no frame expected");
          errors++;
        end else begin
          compare_frame(expected_frames.pop_front());
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_FIRST_SYNC:  sync_first = cfg_wdata;
          REG_SECOND_SYNC: sync_second = cfg_wdata;
          default: ;
        endcase
      end
      if (in_push && !in_full) parse_byte(in_rx_byte);
    end
    outstanding <= expected_frames.size();
  end

endmodule

// ===== bench/tb_sync_framed_message_receiver.sv =====
`timescale 1ns / 1ps
// Top of the sync framed message receiver testbench: clock, reset, byte
// stimulus, result draining and the verdict. Depends on smr_pkg, the block
// and smr_frame_checker, which does all prediction and comparison.
module tb_sync_framed_message_receiver;
  import smr_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [BYTE_W-1:0]    cfg_wdata;
  logic                 in_push;
  logic                 in_full;
  logic [BYTE_W-1:0]    in_rx_byte;
  logic                 out_empty;
  logic                 out_pop;
  logic                 out_frame_status;
  logic [15:0]          out_pos_x;
  logic [15:0]          out_pos_y;
  logic                 out_camera_flag;
  logic                 out_enable_flag;
  logic signed [15:0]   out_angle_deg;
  logic [15:0]          out_range_mm;
  logic [15:0]          out_max_range_mm;
  int                   mismatches;
  int                   outstanding;

  logic [BYTE_W-1:0] sync_a;
  logic [BYTE_W-1:0] sync_b;
  bit                push_burst;
  bit                pop_burst;
  bit                hold_req;
  int                sent;

  sync_framed_message_receiver u_dut (.*);

  smr_frame_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("sync_framed_message_receiver verification failed");
    $finish;
  end

  function automatic logic [BYTE_W-1:0] payload_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return sync_a;
      3: return sync_b;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic payload_t random_payload();
    payload_t p;
    for (int i = 0; i < PAYLOAD_LEN; i++) p[i] = payload_byte();
    return p;
  endfunction

  // counts: byte belongs to a frame or a sync attempt, not plain line noise
  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit counts = 1'b1);
    int gap;
    if ($urandom_range(0, 31) == 0) push_burst = !push_burst;
    gap = push_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push    <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_full);
    if (counts) sent++;
  endtask

  task automatic send_frame(input payload_t body, input bit bad_sum, input int extra_first);
    logic [BYTE_W-1:0] csum;
    csum = '0;
    repeat (extra_first) send_byte(sync_a);
    send_byte(sync_a);
    send_byte(sync_b);
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      send_byte(body[i]);
      csum += body[i];
    end
    if (bad_sum) csum ^= 8'($urandom_range(1, 255));
    send_byte(csum);
  endtask

  task automatic run_random(input int budget);
    int stop;
    stop = sent + budget;
    while (sent < stop) begin
      case ($urandom_range(0, 9))
        0: send_frame(random_payload(), 1'b1, 0);
        1: begin
          repeat ($urandom_range(1, 5))
            send_byte($urandom_range(0, 2) == 0 ? sync_b : 8'($urandom()), 1'b0);
        end
        2: begin
          send_byte(sync_a);
          send_byte($urandom_range(0, 1) ? sync_a : 8'($urandom()));
        end
        3: begin
          // frame cut short: the next frame's bytes land in this payload
          send_byte(sync_a);
          send_byte(sync_b);
          repeat ($urandom_range(1, 11)) send_byte(payload_byte());
        end
        default: send_frame(random_payload(), 1'b0,
                            $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
      endcase
    end
  endtask

  // waits for all results plus pipeline slack, then rewrites both sync bytes
  task automatic reconfigure(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b);
    in_push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_FIRST_SYNC;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_idx   <= REG_SECOND_SYNC;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sync_a = a;
    sync_b = b;
  endtask

  initial begin : pop_side
    int gap;
    out_pop <= 1'b0;
    pop_burst = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_pop <= 1'b0;
        repeat (800) @(posedge clk);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 15) == 0) pop_burst = !pop_burst;
      gap = pop_burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
    end
  end

  initial begin : push_side
    logic [BYTE_W-1:0] v;
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_idx    <= REG_FIRST_SYNC;
    cfg_wdata  <= '0;
    in_push    <= 1'b0;
    in_rx_byte <= '0;
    sync_a     = FIRST_SYNC_RST;
    sync_b     = SECOND_SYNC_RST;
    push_burst = 1'b0;
    hold_req   = 1'b0;
    sent       = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'h00, 1'b0);
    send_frame({8'h00, 8'h00, 8'hFF, 8'hFF, 8'h80, 8'h00,
                8'h80, 8'h01, 8'h00, 8'h00, 8'hFF, 8'hFF}, 1'b0, 1);
    send_byte(sync_a);
    send_byte(8'h12);
    send_frame({8'hFF, 8'hFF, 8'h00, 8'h00, 8'h7F, 8'hFF,
                8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00}, 1'b1, 0);

    hold_req = 1'b1;
    run_random(140);
    reconfigure(8'h00, 8'hFF);
    run_random(130);
    reconfigure(8'hFF, 8'h00);
    run_random(130);
    v = 8'($urandom());
    reconfigure(v, v);
    run_random(130);
    reconfigure(8'($urandom()), 8'($urandom()));
    run_random(130);
    reconfigure(FIRST_SYNC_RST, SECOND_SYNC_RST);
    run_random(130);

    in_push <= 1'b0;
    @(posedge clk);
    for (int n = 0; n < 5000 && outstanding != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("sync_framed_message_receiver verification clean");
    end else begin
      $display("sync_framed_message_receiver verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/smr_pkg.sv
rtl/smr_front.sv
rtl/smr_fifo.sv
rtl/smr_back.sv
rtl/sync_framed_message_receiver.sv
bench/smr_frame_checker.sv
bench/tb_sync_framed_message_receiver.sv
